// ----- sv/rdb_pkg.sv -----
`default_nettype none
package rdb_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int UNIT_WIDTH = 32;
	localparam int CNT_W      = 5;
	localparam int KIND_W     = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_BACK   = 4'd0,
		KIND_PUSH_FRONT  = 4'd1,
		KIND_POP_FRONT   = 4'd2,
		KIND_POP_BACK    = 4'd3,
		KIND_PEEK_FRONT  = 4'd4,
		KIND_PEEK_BACK   = 4'd5,
		KIND_PEEK_AT     = 4'd6,
		KIND_DROP_FRONT  = 4'd7,
		KIND_DROP_BACK   = 4'd8,
		KIND_DEQUEUE_N   = 4'd9,
		KIND_DEQUEUE_MAX = 4'd10,
		KIND_CLEAR       = 4'd11
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [UNIT_WIDTH-1:0] unit_in;
		logic [CNT_W-1:0]      offset_or_count;
	} req_t;

	typedef struct packed {
		logic                  ok;
		logic [UNIT_WIDTH-1:0] unit_out;
		logic                  unit_valid;
		logic [CNT_W-1:0]      moved_count;
		logic [CNT_W-1:0]      fill_level;
		logic                  last;
	} rsp_t;

endpackage
`default_nettype wire

// ----- sv/rdb_ram.sv -----
`default_nettype none
module rdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/ring_deque_buffer.sv -----
`default_nettype none
// Latency: a request accepted at one edge gives its first result in the next cycle.
// Single-unit requests sustain one transfer per cycle: start is taken again in the
// result cycle. A dequeue of N units gives N results on consecutive cycles, one
// unit RAM read each, with busy high for all but the last.
// Reset clears both counters and the control state; RAM contents stay undefined.
// The receiver cannot stall: each result is on rsp for one cycle with strobe high.
module ring_deque_buffer #(
	parameter int DEPTH = rdb_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rdb_pkg::req_t req,
	output logic          strobe,
	output rdb_pkg::rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = AW + 1;
	localparam int CW = rdb_pkg::CNT_W;
	localparam int SW = ((AW > CW) ? AW : CW) + 1;

	typedef struct packed {
		logic          wrap;
		logic [AW-1:0] slot;
	} ptr_t;

	function automatic ptr_t ptr_add(ptr_t p, logic [CW-1:0] n);
		logic [SW-1:0] s;
		ptr_t r;
		r = p;
		s = SW'(p.slot) + SW'(n);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
			r.wrap = ~p.wrap;
		end
		r.slot = s[AW-1:0];
		return r;
	endfunction

	function automatic ptr_t ptr_sub(ptr_t p, logic [CW-1:0] n);
		logic [SW-1:0] s;
		ptr_t r;
		r = p;
		if (SW'(n) > SW'(p.slot)) begin
			s = SW'(p.slot) + SW'(DEPTH) - SW'(n);
			r.wrap = ~p.wrap;
		end else begin
			s = SW'(p.slot) - SW'(n);
		end
		r.slot = s[AW-1:0];
		return r;
	endfunction

	rdb_pkg::state_t state_q, state_d;
	ptr_t            f_q, b_q, f_d, b_d;
	ptr_t            f_inc, f_dec, b_dec, f_addn, b_subn;
	logic [CW-1:0]   rem_q, rem_d;
	logic            ok_q, valid_q;
	logic [CW-1:0]   moved_q;

	logic [FW-1:0]   fill;
	logic [SW-1:0]   fill_w, n_w;
	logic            empty, full, acc, last_now, cont;
	logic [CW-1:0]   n;
	logic [CW-1:0]   deq_cnt;
	logic            is_deq;

	logic            dec_ok, dec_valid, dec_we;
	logic [CW-1:0]   dec_moved, dec_cnt;
	logic [AW-1:0]   dec_raddr, dec_waddr;
	ptr_t            dec_f, dec_b;

	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [rdb_pkg::UNIT_WIDTH-1:0] ram_rdata;

	assign n      = req.offset_or_count;
	assign fill   = (f_q.wrap == b_q.wrap) ? ({1'b0, b_q.slot} - {1'b0, f_q.slot})
	                : (FW'(DEPTH) + {1'b0, b_q.slot} - {1'b0, f_q.slot});
	assign fill_w = SW'(fill);
	assign n_w    = SW'(n);
	assign empty  = (fill == '0);
	assign full   = (fill_w == SW'(DEPTH));

	assign f_inc  = ptr_add(f_q, CW'(1));
	assign f_dec  = ptr_sub(f_q, CW'(1));
	assign b_dec  = ptr_sub(b_q, CW'(1));
	assign f_addn = ptr_add(f_q, n);
	assign b_subn = ptr_sub(b_q, n);

	assign last_now = (rem_q == CW'(1));
	assign cont     = (state_q == rdb_pkg::ST_RESP) && !last_now;
	assign acc      = start && !busy;

	always_comb begin
		dec_ok    = 1'b0;
		dec_valid = 1'b0;
		dec_we    = 1'b0;
		dec_moved = '0;
		dec_cnt   = CW'(1);
		dec_raddr = f_q.slot;
		dec_waddr = b_q.slot;
		dec_f     = f_q;
		dec_b     = b_q;
		is_deq    = 1'b0;
		deq_cnt   = '0;
		case (rdb_pkg::kind_t'(req.kind))
			rdb_pkg::KIND_PUSH_BACK: begin
				if (!full) begin
					dec_ok    = 1'b1;
					dec_we    = 1'b1;
					dec_moved = CW'(1);
					dec_b     = ptr_add(b_q, CW'(1));
				end
			end
			rdb_pkg::KIND_PUSH_FRONT: begin
				if (!full) begin
					dec_ok    = 1'b1;
					dec_we    = 1'b1;
					dec_moved = CW'(1);
					dec_waddr = f_dec.slot;
					dec_f     = f_dec;
				end
			end
			rdb_pkg::KIND_POP_FRONT: begin
				if (!empty) begin
					dec_ok    = 1'b1;
					dec_valid = 1'b1;
					dec_moved = CW'(1);
					dec_f     = f_inc;
				end
			end
			rdb_pkg::KIND_POP_BACK: begin
				if (!empty) begin
					dec_ok    = 1'b1;
					dec_valid = 1'b1;
					dec_moved = CW'(1);
					dec_raddr = b_dec.slot;
					dec_b     = b_dec;
				end
			end
			rdb_pkg::KIND_PEEK_FRONT: begin
				if (!empty) begin
					dec_ok    = 1'b1;
					dec_valid = 1'b1;
				end
			end
			rdb_pkg::KIND_PEEK_BACK: begin
				if (!empty) begin
					dec_ok    = 1'b1;
					dec_valid = 1'b1;
					dec_raddr = b_dec.slot;
				end
			end
			rdb_pkg::KIND_PEEK_AT: begin
				if (n_w < fill_w) begin
					dec_ok    = 1'b1;
					dec_valid = 1'b1;
					dec_raddr = f_addn.slot;
				end
			end
			rdb_pkg::KIND_DROP_FRONT: begin
				if (n_w <= fill_w) begin
					dec_ok    = 1'b1;
					dec_moved = n;
					dec_f     = f_addn;
				end
			end
			rdb_pkg::KIND_DROP_BACK: begin
				if (n_w <= fill_w) begin
					dec_ok    = 1'b1;
					dec_moved = n;
					dec_b     = b_subn;
				end
			end
			rdb_pkg::KIND_DEQUEUE_N: begin
				if (n_w <= fill_w) begin
					is_deq  = 1'b1;
					deq_cnt = n;
				end
			end
			rdb_pkg::KIND_DEQUEUE_MAX: begin
				is_deq  = 1'b1;
				deq_cnt = (n_w < fill_w) ? n : CW'(fill);
			end
			rdb_pkg::KIND_CLEAR: begin
				dec_ok    = 1'b1;
				dec_moved = CW'(fill);
				dec_f     = '0;
				dec_b     = '0;
			end
			default: begin
			end
		endcase
		if (is_deq) begin
			dec_ok = 1'b1;
			if (deq_cnt != '0) begin
				dec_valid = 1'b1;
				dec_moved = deq_cnt;
				dec_cnt   = deq_cnt;
				dec_f     = f_inc;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		f_d       = f_q;
		b_d       = b_q;
		rem_d     = rem_q;
		ram_we    = 1'b0;
		ram_raddr = dec_raddr;
		if (cont) begin
			ram_raddr = f_q.slot;
			f_d       = f_inc;
			rem_d     = rem_q - CW'(1);
		end else if (acc) begin
			state_d = rdb_pkg::ST_RESP;
			ram_we  = dec_we;
			f_d     = dec_f;
			b_d     = dec_b;
			rem_d   = dec_cnt;
		end else if (state_q == rdb_pkg::ST_RESP) begin
			state_d = rdb_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdb_pkg::ST_IDLE;
			f_q     <= '0;
			b_q     <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			f_q     <= f_d;
			b_q     <= b_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q    <= dec_ok;
			valid_q <= dec_valid;
			moved_q <= dec_moved;
		end
	end

	rdb_ram #(
		.WIDTH (rdb_pkg::UNIT_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dec_waddr),
		.wdata (req.unit_in),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = cont;
	assign strobe = (state_q == rdb_pkg::ST_RESP);

	always_comb begin
		rsp.ok          = ok_q;
		rsp.unit_out    = valid_q ? ram_rdata : '0;
		rsp.unit_valid  = valid_q;
		rsp.moved_count = moved_q;
		rsp.fill_level  = CW'(fill);
		rsp.last        = last_now;
	end

	a_busy_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe)
		else $error("busy outside a result cycle");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_w <= SW'(DEPTH))
		else $error("fill beyond depth");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("accepted transfer without result");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.unit_valid) |-> rsp.ok)
		else $error("unit returned on refusal");

endmodule
`default_nettype wire
